// File: hdl/amb_pkg.sv
// Package: shared types and codes for the alpha mask bounding box block.
package amb_pkg;

    // Request codes carried in req_type
    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_PIXEL = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ALPHA_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_FRAME_WIDTH     = 3'd1;
    localparam logic [2:0] CFG_FRAME_HEIGHT    = 3'd2;
    localparam logic [2:0] CFG_MAKE_MASK       = 3'd3;
    localparam logic [2:0] CFG_TRACK_BOUNDS    = 3'd4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] alpha;
        logic [7:0] query_x;
        logic [7:0] query_y;
    } req_t;

    typedef struct packed {
        logic       solid;
        logic [7:0] box_x;
        logic [7:0] box_y;
        logic [8:0] box_w;
        logic [8:0] box_h;
        logic       scan_done;
    } rsp_t;

endpackage

// File: hdl/amb_req_if.sv
// Interface: request channel carrying begin, pixel and query beats.
interface amb_req_if;
    import amb_pkg::*;

    logic          valid;
    logic          ready;
    amb_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/amb_rsp_if.sv
// Interface: result channel carrying one beat per request.
interface amb_rsp_if;
    import amb_pkg::*;

    logic          valid;
    logic          ready;
    amb_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/amb_cfg_if.sv
// Interface: configuration write channel with register index and data.
interface amb_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [8:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/amb_ram.sv
// Generic single-bit-or-wider RAM: one write port, one read port, registered read.
module amb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: hdl/alpha_mask_bounding_box_top.sv
// Top level: alpha threshold mask and bounding box of solid pixels.
//
// Usage:
//   req  : request beats. req_type selects begin scan, next pixel alpha, or
//          query of one pixel's solid bit from the last completed scan.
//   rsp  : exactly one result beat per request beat, in order. Each carries
//          the query answer, the bounding box so far and scan_done.
//   cfg  : register writes (threshold, window size, mask and bounds enables),
//          always ready; write only while the block is idle.
// Path: a request beat is registered into a result stage that also holds the
//   mask read, then into the output register that drives rsp.
// Throughput: one request beat per cycle while rsp does not stall, set by the
//   state update and the one mask memory port used per beat (pixel write or
//   query read).
// Stall: when rsp.ready is low, the output register and the result stage
//   hold; req.ready drops only once both are full, so no beat is lost.
// Reset: clears the scan state, the box, mask_ready and both valid stages;
//   registers return to their reset values. The mask memory needs no clearing
//   pass: a mask is only read after a full scan has written every entry.
module alpha_mask_bounding_box_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    amb_req_if.sink   req,
    amb_rsp_if.source rsp,
    amb_cfg_if.sink   cfg
);
    import amb_pkg::*;

    // Column / row index widths and widths that can hold the maxima
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SW  = $clog2(MAX_WIDTH + 1);
    localparam int RSW = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = CW + RW;

    // ---------------- configuration registers ----------------
    logic [7:0] alpha_threshold_reg;
    logic [8:0] frame_width_reg;
    logic [8:0] frame_height_reg;
    logic       make_mask_reg;
    logic       track_bounds_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_threshold_reg <= 8'd0;
            frame_width_reg     <= 9'd256;
            frame_height_reg    <= 9'd256;
            make_mask_reg       <= 1'b1;
            track_bounds_reg    <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ALPHA_THRESHOLD: alpha_threshold_reg <= cfg.data[7:0];
                CFG_FRAME_WIDTH:     frame_width_reg     <= cfg.data;
                CFG_FRAME_HEIGHT:    frame_height_reg    <= cfg.data;
                CFG_MAKE_MASK:       make_mask_reg       <= cfg.data[0];
                CFG_TRACK_BOUNDS:    track_bounds_reg    <= cfg.data[0];
                default:             ;  // unmapped index: drop the write
            endcase
        end
    end

    // ---------------- scan state ----------------
    logic [SW-1:0]  scan_w_reg,      scan_w_next;
    logic [RSW-1:0] scan_h_reg,      scan_h_next;
    logic [CW-1:0]  col_pos_reg,     col_pos_next;
    logic [RW-1:0]  row_pos_reg,     row_pos_next;
    logic           scan_active_reg, scan_active_next;
    logic           mask_ready_reg,  mask_ready_next;
    logic           mask_whole_reg,  mask_whole_next;
    logic           any_solid_reg,   any_solid_next;
    logic [CW-1:0]  left_edge_reg,   left_edge_next;
    logic [RW-1:0]  top_edge_reg,    top_edge_next;
    logic [SW-1:0]  right_edge_reg,  right_edge_next;
    logic [RSW-1:0] bottom_edge_reg, bottom_edge_next;

    // ---------------- pipeline stages ----------------
    logic           s1_valid_reg,  s1_valid_next;
    logic           s1_hit_reg;
    logic           s1_any_reg;
    logic           s1_done_reg;
    logic [CW-1:0]  s1_left_reg;
    logic [RW-1:0]  s1_top_reg;
    logic [SW-1:0]  s1_right_reg;
    logic [RSW-1:0] s1_bottom_reg;
    logic           out_valid_reg, out_valid_next;
    rsp_t           out_data_reg,  out_data_next;

    logic req_accept;
    logic s1_advance;
    logic is_begin, is_pixel, is_query;
    logic pix_step;
    logic pix_solid;
    logic col_last, row_last;
    logic done_now;
    logic query_hit;

    logic [SW-1:0]  col_inc;
    logic [RSW-1:0] row_inc;
    logic [31:0]    fw32, fh32, clamp_w32, clamp_h32;
    logic [31:0]    wdiff, hdiff;

    logic          ram_we, ram_re, ram_rdata;
    logic [AW-1:0] ram_waddr, ram_raddr;

    // Handshake: take a beat when the result stage is empty or moving on
    assign s1_advance = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign req_accept = req.valid && req.ready;

    assign is_begin = (req.data.req_type == REQ_BEGIN);
    assign is_pixel = (req.data.req_type == REQ_PIXEL);
    assign is_query = (req.data.req_type == REQ_QUERY);

    assign pix_step  = req_accept && is_pixel && scan_active_reg;
    assign pix_solid = req.data.alpha > alpha_threshold_reg;

    assign col_inc  = SW'(col_pos_reg) + SW'(1);
    assign row_inc  = RSW'(row_pos_reg) + RSW'(1);
    assign col_last = (col_inc == scan_w_reg);
    assign row_last = (row_inc == scan_h_reg);

    // Window size clamp: zero acts as one, above the maximum acts as the maximum
    assign fw32 = 32'(frame_width_reg);
    assign fh32 = 32'(frame_height_reg);
    assign clamp_w32 = (fw32 == 32'd0) ? 32'd1 :
                       (fw32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : fw32;
    assign clamp_h32 = (fh32 == 32'd0) ? 32'd1 :
                       (fh32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : fh32;

    // Query answers only from a ready mask and inside the latched window
    assign query_hit = make_mask_reg && mask_ready_reg
                       && (32'(req.data.query_x) < 32'(scan_w_reg))
                       && (32'(req.data.query_y) < 32'(scan_h_reg));

    always_comb
    begin
        scan_w_next      = scan_w_reg;
        scan_h_next      = scan_h_reg;
        col_pos_next     = col_pos_reg;
        row_pos_next     = row_pos_reg;
        scan_active_next = scan_active_reg;
        mask_ready_next  = mask_ready_reg;
        mask_whole_next  = mask_whole_reg;
        any_solid_next   = any_solid_reg;
        left_edge_next   = left_edge_reg;
        top_edge_next    = top_edge_reg;
        right_edge_next  = right_edge_reg;
        bottom_edge_next = bottom_edge_reg;
        done_now         = 1'b0;

        if (req_accept && is_begin)
        begin
            // Restart: latch the window and drop the previous box and mask
            scan_w_next      = SW'(clamp_w32);
            scan_h_next      = RSW'(clamp_h32);
            col_pos_next     = '0;
            row_pos_next     = '0;
            scan_active_next = 1'b1;
            mask_ready_next  = 1'b0;
            mask_whole_next  = 1'b1;
            any_solid_next   = 1'b0;
            left_edge_next   = '0;
            top_edge_next    = '0;
            right_edge_next  = '0;
            bottom_edge_next = '0;
        end
        else if (pix_step)
        begin
            if (!make_mask_reg)
            begin
                mask_whole_next = 1'b0;
            end
            if (track_bounds_reg && pix_solid)
            begin
                if (!any_solid_reg)
                begin
                    left_edge_next   = col_pos_reg;
                    top_edge_next    = row_pos_reg;
                    right_edge_next  = col_inc;
                    bottom_edge_next = row_inc;
                    any_solid_next   = 1'b1;
                end
                else
                begin
                    if (col_pos_reg < left_edge_reg)
                    begin
                        left_edge_next = col_pos_reg;
                    end
                    if (row_pos_reg < top_edge_reg)
                    begin
                        top_edge_next = row_pos_reg;
                    end
                    if (col_inc > right_edge_reg)
                    begin
                        right_edge_next = col_inc;
                    end
                    if (row_inc > bottom_edge_reg)
                    begin
                        bottom_edge_next = row_inc;
                    end
                end
            end
            // Advance the raster position; close the scan after the last pixel
            if (col_last)
            begin
                col_pos_next = '0;
                if (row_last)
                begin
                    row_pos_next     = '0;
                    scan_active_next = 1'b0;
                    mask_ready_next  = mask_whole_next;
                    done_now         = 1'b1;
                end
                else
                begin
                    row_pos_next = row_pos_reg + RW'(1);
                end
            end
            else
            begin
                col_pos_next = col_pos_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_w_reg      <= SW'(MAX_WIDTH);
            scan_h_reg      <= RSW'(MAX_HEIGHT);
            col_pos_reg     <= '0;
            row_pos_reg     <= '0;
            scan_active_reg <= 1'b0;
            mask_ready_reg  <= 1'b0;
            mask_whole_reg  <= 1'b0;
            any_solid_reg   <= 1'b0;
            left_edge_reg   <= '0;
            top_edge_reg    <= '0;
            right_edge_reg  <= '0;
            bottom_edge_reg <= '0;
        end
        else
        begin
            scan_w_reg      <= scan_w_next;
            scan_h_reg      <= scan_h_next;
            col_pos_reg     <= col_pos_next;
            row_pos_reg     <= row_pos_next;
            scan_active_reg <= scan_active_next;
            mask_ready_reg  <= mask_ready_next;
            mask_whole_reg  <= mask_whole_next;
            any_solid_reg   <= any_solid_next;
            left_edge_reg   <= left_edge_next;
            top_edge_reg    <= top_edge_next;
            right_edge_reg  <= right_edge_next;
            bottom_edge_reg <= bottom_edge_next;
        end
    end

    // ---------------- mask memory ----------------
    // Address as {row, column}; one port busy per beat
    assign ram_we    = pix_step && make_mask_reg;
    assign ram_waddr = {row_pos_reg, col_pos_reg};
    assign ram_re    = req_accept && is_query && query_hit;
    assign ram_raddr = {RW'(req.data.query_y), CW'(req.data.query_x)};

    amb_ram #(
        .WIDTH (1),
        .DEPTH (1 << AW)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pix_solid),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- result stage and output register ----------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Capture the post-update box with each beat; sizes formed on the way out
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_hit_reg    <= is_query && query_hit;
            s1_any_reg    <= any_solid_next;
            s1_done_reg   <= done_now;
            s1_left_reg   <= left_edge_next;
            s1_top_reg    <= top_edge_next;
            s1_right_reg  <= right_edge_next;
            s1_bottom_reg <= bottom_edge_next;
        end
    end

    assign wdiff = 32'(s1_right_reg) - 32'(s1_left_reg);
    assign hdiff = 32'(s1_bottom_reg) - 32'(s1_top_reg);

    always_comb
    begin
        out_data_next.solid     = s1_hit_reg && ram_rdata;
        out_data_next.scan_done = s1_done_reg;
        if (s1_any_reg)
        begin
            out_data_next.box_x = 8'(s1_left_reg);
            out_data_next.box_y = 8'(s1_top_reg);
            out_data_next.box_w = wdiff[8:0];
            out_data_next.box_h = hdiff[8:0];
        end
        else
        begin
            out_data_next.box_x = 8'd0;
            out_data_next.box_y = 8'd0;
            out_data_next.box_w = 9'd0;
            out_data_next.box_h = 9'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule
